/* hw/rtl/murmurhash2_32_stream_core_assert.svh */
// ----------------------------------------------------------------------------
// MurmurHash2 stream core assertion macros
// Shared property wrappers for the hash core checks.
// ----------------------------------------------------------------------------
`ifndef MURMURHASH2_32_STREAM_CORE_ASSERT_SVH
`define MURMURHASH2_32_STREAM_CORE_ASSERT_SVH

// Checks an implication on every rising edge outside of reset.
`define MH2_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks an implication in the following cycle on every rising edge outside of reset.
`define MH2_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mh2_pkg.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 package
// Constants, datapath operation codes and control structures.
// ----------------------------------------------------------------------------
`default_nettype none

package mh2_pkg;

  localparam logic [31:0] MixMul    = 32'h5bd1e995;
  localparam int unsigned MixShift  = 24;
  localparam int unsigned FinShiftA = 13;
  localparam int unsigned FinShiftB = 15;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_KEY1,
    OP_KEY2,
    OP_HASH,
    OP_TAIL,
    OP_FIN
  } op_e;

  typedef struct packed {
    logic load;
    logic use_seed;
    op_e  op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_full;
    logic in_zero;
    logic in_last;
    logic last_q;
  } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/mh2_datapath.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 datapath
// Holds the seed, running hash, scrambled key and result, around one
// shared multiplier by the mixing constant.
// ----------------------------------------------------------------------------
`default_nettype none

module mh2_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 seed_we_i,
  input  wire logic [31:0]          seed_i,
  input  wire logic [31:0]          data_word_i,
  input  wire logic [2:0]           byte_count_i,
  input  wire logic                 last_word_i,
  input  wire logic [31:0]          message_length_i,
  input  wire mh2_pkg::dp_cmd_t     cmd_i,
  output mh2_pkg::dp_status_t       status_o,
  output logic [31:0]               hash_value_o
);

  logic [31:0] seed_q;
  logic [31:0] hash_q, hash_d;
  logic [31:0] key_q, key_d;
  logic [31:0] word_q;
  logic [1:0]  cnt_q;
  logic        last_q;
  logic [31:0] out_q, out_d;
  logic [31:0] tail_mask;
  logic [31:0] mul_a;
  logic [31:0] prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_we_i) begin
      seed_q <= seed_i;
    end
  end

  always_comb begin
    case (cnt_q)
      2'd1:    tail_mask = 32'h0000_00ff;
      2'd2:    tail_mask = 32'h0000_ffff;
      default: tail_mask = 32'h00ff_ffff;
    endcase
  end

  always_comb begin
    unique case (cmd_i.op)
      mh2_pkg::OP_KEY1: mul_a = word_q;
      mh2_pkg::OP_KEY2: mul_a = key_q ^ (key_q >> mh2_pkg::MixShift);
      mh2_pkg::OP_HASH: mul_a = hash_q;
      mh2_pkg::OP_TAIL: mul_a = hash_q ^ (word_q & tail_mask);
      mh2_pkg::OP_FIN:  mul_a = hash_q ^ (hash_q >> mh2_pkg::FinShiftA);
      default:          mul_a = hash_q;
    endcase
  end

  assign prod = mul_a * mh2_pkg::MixMul;

  always_comb begin
    hash_d = hash_q;
    key_d  = key_q;
    out_d  = out_q;
    if (cmd_i.load) begin
      hash_d = cmd_i.use_seed ? (seed_q ^ message_length_i) : hash_q;
    end else begin
      unique case (cmd_i.op)
        mh2_pkg::OP_KEY1,
        mh2_pkg::OP_KEY2: key_d  = prod;
        mh2_pkg::OP_HASH: hash_d = prod ^ key_q;
        mh2_pkg::OP_TAIL: hash_d = prod;
        mh2_pkg::OP_FIN:  out_d  = prod ^ (prod >> mh2_pkg::FinShiftB);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      key_q  <= '0;
      out_q  <= '0;
      word_q <= '0;
      cnt_q  <= '0;
      last_q <= 1'b0;
    end else begin
      hash_q <= hash_d;
      key_q  <= key_d;
      out_q  <= out_d;
      if (cmd_i.load) begin
        word_q <= data_word_i;
        cnt_q  <= byte_count_i[1:0];
        last_q <= last_word_i;
      end
    end
  end

  assign status_o.in_full = byte_count_i[2];
  assign status_o.in_zero = (byte_count_i == 3'd0);
  assign status_o.in_last = last_word_i;
  assign status_o.last_q  = last_q;
  assign hash_value_o     = out_q;

endmodule

`default_nettype wire

/* hw/rtl/mh2_ctrl.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 controller
// Sequences the shared multiplier through the body, tail and finalization
// steps and manages both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module mh2_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire mh2_pkg::dp_status_t  status_i,
  output mh2_pkg::dp_cmd_t          cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_KEY1 = 6'b000010,
    ST_KEY2 = 6'b000100,
    ST_HASH = 6'b001000,
    ST_TAIL = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   in_msg_q, in_msg_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d        = state_q;
    in_msg_d       = in_msg_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    cmd_o.load     = accept;
    cmd_o.use_seed = !in_msg_q;
    cmd_o.op       = mh2_pkg::OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_msg_d = !status_i.in_last;
          if (status_i.in_full) begin
            state_d = ST_KEY1;
          end else if (!status_i.in_zero) begin
            state_d = ST_TAIL;
          end else if (status_i.in_last) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_KEY1: begin
        cmd_o.op = mh2_pkg::OP_KEY1;
        state_d  = ST_KEY2;
      end
      ST_KEY2: begin
        cmd_o.op = mh2_pkg::OP_KEY2;
        state_d  = ST_HASH;
      end
      ST_HASH: begin
        cmd_o.op = mh2_pkg::OP_HASH;
        state_d  = status_i.last_q ? ST_FIN : ST_IDLE;
      end
      ST_TAIL: begin
        cmd_o.op = mh2_pkg::OP_TAIL;
        state_d  = status_i.last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = mh2_pkg::OP_FIN;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/murmurhash2_32_stream_core.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 32-bit stream core
// Hashes a message of little-endian words with a configurable seed.
// ----------------------------------------------------------------------------
// A full word runs the key, key and hash steps and a 1 to 3 byte word the tail
// step before the input is ready again; an empty word needs no step. The steps
// run one after another on the shared 32x32 multiplier. A last word adds a
// finalization step, which waits for an unread hash; the hash is registered.
// Reset clears the seed to zero and returns the core to idle between messages.
`default_nettype none

`include "murmurhash2_32_stream_core_assert.svh"

module murmurhash2_32_stream_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        seed_we_i,
  input  wire logic [31:0] seed_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_word_i,
  input  wire logic [31:0] message_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      hash_value_o
);

  mh2_pkg::dp_cmd_t    cmd;
  mh2_pkg::dp_status_t status;

  mh2_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mh2_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .seed_we_i        (seed_we_i),
    .seed_i           (seed_i),
    .data_word_i      (data_word_i),
    .byte_count_i     (byte_count_i),
    .last_word_i      (last_word_i),
    .message_length_i (message_length_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .hash_value_o     (hash_value_o)
  );

  `MH2_ASSERT_NEXT(a_busy_after_data, clk_i, rst_ni,
    in_valid_i && in_ready_o && (byte_count_i != 3'd0), !in_ready_o,
    "core accepted a request while still mixing a word")

  `MH2_ASSERT_IMPL(a_empty_last_result, clk_i, rst_ni,
    in_valid_i && in_ready_o && last_word_i && (byte_count_i == 3'd0) && !out_valid_o,
    ##2 out_valid_o,
    "empty last word did not produce a hash in time")

endmodule

`default_nettype wire
